/* rtl/core/ieu_pkg.sv */
// ----------------------------------------------------------------------------
// ieu_pkg: shared types and constants of the execute unit
// Opcode codes, status codes, memory operation codes and the queue entry type.
// ----------------------------------------------------------------------------
package ieu_pkg;

	localparam int NumRegs   = 8;
	localparam int WordWidth = 64;
	localparam int RegIdxW   = $clog2(NumRegs);
	localparam int QDepth    = 2;

	localparam logic [2:0] RetReg = 3'd7;
	localparam logic [1:0] PtrPc  = 2'd0;
	localparam logic [1:0] PtrSp  = 2'd1;

	typedef enum logic [5:0] {
		OP_ADD2 = 6'd0, OP_ADD2I = 6'd1, OP_SUB2 = 6'd2, OP_SUB2I = 6'd3,
		OP_CMP = 6'd4, OP_CMPI = 6'd5, OP_LET = 6'd6, OP_LETI = 6'd7,
		OP_SHIFT = 6'd8, OP_READZE = 6'd9, OP_READSE = 6'd10, OP_JUMP = 6'd11,
		OP_JUMPIF = 6'd12, OP_OR2 = 6'd13, OP_OR2I = 6'd14, OP_AND2 = 6'd15,
		OP_AND2I = 6'd16, OP_WRITE = 6'd17, OP_CALL = 6'd18, OP_SETCTR = 6'd19,
		OP_GETCTR = 6'd20, OP_PUSH = 6'd21, OP_RETURN = 6'd22, OP_ADD3 = 6'd23,
		OP_ADD3I = 6'd24, OP_SUB3 = 6'd25, OP_SUB3I = 6'd26, OP_AND3 = 6'd27,
		OP_AND3I = 6'd28, OP_OR3 = 6'd29, OP_OR3I = 6'd30, OP_XOR3 = 6'd31,
		OP_XOR3I = 6'd32, OP_ASR3 = 6'd33
	} opcode_t;

	localparam logic [5:0] OpcodeLimit = 6'd34;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_LOAD    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;
	localparam logic [1:0] ST_STACK   = 2'd3;

	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_READ  = 2'd1;
	localparam logic [1:0] MEM_WRITE = 2'd2;

	localparam logic [1:0] CFG_STACK = 2'd0;
	localparam logic [1:0] CFG_DATA  = 2'd1;
	localparam logic [1:0] CFG_VRAM  = 2'd2;
	localparam logic [1:0] CFG_TEXT  = 2'd3;

	// One classified beat as it travels from the front to the back.
	typedef struct packed {
		logic                 is_load;
		logic                 illegal;
		logic [5:0]           opcode;
		logic [RegIdxW-1:0]   reg_d;
		logic [RegIdxW-1:0]   reg_m;
		logic [RegIdxW-1:0]   reg_n;
		logic [2:0]           sel;
		logic [6:0]           sz;
		logic [WordWidth-1:0] konst;
		logic [6:0]           len;
		logic [WordWidth-1:0] load_data;
	} ieu_item_t;

endpackage

/* rtl/core/ieu_front.sv */
// ----------------------------------------------------------------------------
// ieu_front: input classification and decoupling queue
// Accepts beats, clamps sizes, flags illegal opcodes and queues the result.
// ----------------------------------------------------------------------------
module ieu_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	output logic                    ready,
	input  logic                    req_type,
	input  logic [5:0]              opcode,
	input  logic [2:0]              reg_d,
	input  logic [2:0]              reg_m,
	input  logic [2:0]              reg_n,
	input  logic [2:0]              small_select,
	input  logic [6:0]              size_or_shift,
	input  logic signed [63:0]      constant,
	input  logic [6:0]              insn_length,
	input  logic [63:0]             load_data,
	output logic                    q_valid,
	input  logic                    q_pop,
	output ieu_pkg::ieu_item_t      q_item
);
	import ieu_pkg::*;

	ieu_item_t                     entry_q [QDepth];
	logic [$clog2(QDepth)-1:0]     wr_ptr_q, rd_ptr_q;
	logic [$clog2(QDepth):0]       count_q;
	ieu_item_t                     cls;
	logic                          push;

	always_comb begin
		cls.is_load   = req_type;
		cls.illegal   = (opcode >= OpcodeLimit);
		cls.opcode    = opcode;
		cls.reg_d     = reg_d;
		cls.reg_m     = reg_m;
		cls.reg_n     = reg_n;
		cls.sel       = small_select;
		cls.sz        = (size_or_shift > 7'd64) ? 7'd64 : size_or_shift;
		cls.konst     = constant;
		cls.len       = insn_length;
		cls.load_data = load_data;
	end

	assign ready   = (count_q != QDepth[$clog2(QDepth):0]);
	assign push    = valid && ready;
	assign q_valid = (count_q != '0);
	assign q_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/ieu_back.sv */
// ----------------------------------------------------------------------------
// ieu_back: architectural state, ALU and result register
// Executes one queued beat per cycle unless its held result is still untaken.
// ----------------------------------------------------------------------------
module ieu_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [63:0]          cfg_data,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  ieu_pkg::ieu_item_t   q_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           mem_op,
	output logic [63:0]          mem_addr,
	output logic [6:0]           mem_size,
	output logic [63:0]          store_data,
	output logic [63:0]          pc_value,
	output logic [3:0]           flags_nzcv,
	output logic                 halted,
	output logic [1:0]           status
);
	import ieu_pkg::*;

	logic [63:0] gp_q [NumRegs];
	logic [63:0] ptr_q [4];
	logic [63:0] text_base_q;
	logic [3:0]  flags_q;
	logic        halt_q;
	logic        pend_valid_q, pend_signed_q;
	logic [2:0]  pend_reg_q;
	logic [6:0]  pend_size_q;
	logic        ov_q;

	// Next-state values computed by the ALU pass.
	logic        gp_we;
	logic [2:0]  gp_wa;
	logic [63:0] gp_wd;
	logic        ptr_we;
	logic [1:0]  ptr_wa;
	logic [63:0] ptr_wd;
	logic [63:0] pc_n;
	logic [3:0]  flags_n;
	logic        halt_n;
	logic        pend_set, pend_clr;
	logic [1:0]  r_op, r_st;
	logic [63:0] r_addr, r_data;
	logic [6:0]  r_size;

	logic [63:0] xd, xm, xn, b, npc, base, res, nsp, ld, msk, tgt, pv;
	logic [64:0] sum;
	logic        n_f, z_f, c_f, v_f, cnd;
	logic [6:0]  sz;
	logic [1:0]  pi;
	logic [127:0] wide;

	assign q_pop = q_valid && (!ov_q || out_ready);

	always_comb begin
		gp_we = 1'b0; gp_wa = q_item.reg_d; gp_wd = '0;
		ptr_we = 1'b0; ptr_wa = '0; ptr_wd = '0;
		flags_n = flags_q; halt_n = halt_q;
		pend_set = 1'b0; pend_clr = 1'b0;
		r_op = MEM_NONE; r_st = ST_OK; r_addr = '0; r_data = '0; r_size = '0;
		sz = q_item.sz;
		pi = q_item.sel[1:0];
		xd = gp_q[q_item.reg_d];
		xm = gp_q[q_item.reg_m];
		xn = gp_q[q_item.reg_n];
		base = ptr_q[PtrPc];
		npc = base + {57'd0, q_item.len};
		// The PC counter already points past the instruction when it is used.
		pv = (pi == PtrPc) ? npc : ptr_q[pi];
		pc_n = base;
		nsp = ptr_q[PtrSp] - {57'd0, sz};
		tgt = npc + q_item.konst;
		res = '0; sum = '0; b = '0; wide = '0;
		n_f = 1'b0; z_f = 1'b0; c_f = 1'b0; v_f = flags_q[0];
		msk = (pend_size_q == 7'd0) ? 64'd0 :
			(pend_size_q >= 7'd64) ? '1 : ((64'd1 << pend_size_q[5:0]) - 64'd1);
		ld = q_item.load_data & msk;
		if (pend_signed_q && pend_size_q != 7'd0 && pend_size_q < 7'd64 &&
			ld[pend_size_q[5:0] - 6'd1]) begin
			ld = ld | ~msk;
		end
		case (q_item.sel)
			3'd0:    cnd = flags_q[2];
			3'd1:    cnd = !flags_q[2];
			3'd2:    cnd = !flags_q[2] && (flags_q[3] == flags_q[0]);
			3'd3:    cnd = flags_q[3] != flags_q[0];
			3'd4:    cnd = !flags_q[1] && !flags_q[2];
			3'd5:    cnd = !flags_q[1];
			3'd6:    cnd = flags_q[1];
			default: cnd = flags_q[0];
		endcase

		if (q_item.is_load) begin
			if (pend_valid_q) begin
				gp_we = 1'b1; gp_wa = pend_reg_q; gp_wd = ld; pend_clr = 1'b1;
			end
		end else if (q_item.illegal) begin
			r_st = ST_ILLEGAL;
		end else if (q_item.opcode == OP_PUSH) begin
			if (nsp < text_base_q) begin
				r_st = ST_STACK;
			end else begin
				pc_n = npc; ptr_we = 1'b1; ptr_wa = PtrSp; ptr_wd = nsp;
				r_op = MEM_WRITE; r_addr = nsp; r_size = sz; r_data = xd;
			end
		end else begin
			pc_n = npc;
			// Operand selection for the adder.
			case (q_item.opcode)
				OP_ADD2I, OP_SUB2I, OP_CMPI, OP_ADD3I, OP_SUB3I: b = q_item.konst;
				OP_ADD3, OP_SUB3: b = xn;
				default: b = xm;
			endcase
			case (q_item.opcode)
				OP_ADD3, OP_ADD3I, OP_SUB3, OP_SUB3I: res = xm;
				default: res = xd;
			endcase
			case (q_item.opcode)
				OP_ADD2, OP_ADD2I, OP_ADD3, OP_ADD3I: begin
					sum = {1'b0, res} + {1'b0, b};
					c_f = sum[64];
					v_f = ~(res[63] ^ b[63]) & (res[63] ^ sum[63]);
				end
				default: begin
					sum = {1'b0, res} - {1'b0, b};
					c_f = sum[64];
					v_f = (res[63] ^ b[63]) & (res[63] ^ sum[63]);
				end
			endcase
			n_f = sum[63]; z_f = (sum[63:0] == '0);
			case (q_item.opcode)
				OP_ADD2, OP_ADD2I, OP_SUB2, OP_SUB2I, OP_ADD3, OP_ADD3I,
				OP_SUB3, OP_SUB3I: begin
					gp_we = 1'b1; gp_wd = sum[63:0];
					flags_n = {n_f, z_f, c_f, v_f};
				end
				OP_CMP, OP_CMPI: flags_n = {n_f, z_f, c_f, v_f};
				OP_LET: begin gp_we = 1'b1; gp_wd = xm; end
				OP_LETI: begin gp_we = 1'b1; gp_wd = q_item.konst; end
				OP_SHIFT: begin
					if (sz == 7'd0) begin
						res = xd; c_f = 1'b0;
					end else if (q_item.sel != 3'd0) begin
						wide = {xd, 64'd0} >> sz;
						res = wide[127:64]; c_f = wide[63];
					end else begin
						wide = {64'd0, xd} << sz;
						res = wide[63:0]; c_f = wide[64];
					end
					gp_we = 1'b1; gp_wd = res;
					flags_n = {res[63], res == '0, c_f, flags_q[0]};
				end
				OP_ASR3: begin
					if (sz == 7'd0) begin
						res = xm; c_f = 1'b0;
					end else begin
						wide = $signed({xm, 64'd0}) >>> sz;
						res = wide[127:64]; c_f = wide[63];
					end
					gp_we = 1'b1; gp_wd = res;
					flags_n = {res[63], res == '0, c_f, flags_q[0]};
				end
				OP_READZE, OP_READSE: begin
					ptr_we = 1'b1; ptr_wa = pi; ptr_wd = pv + {57'd0, sz};
					pend_set = 1'b1;
					r_op = MEM_READ; r_addr = pv; r_size = sz; r_st = ST_LOAD;
				end
				OP_WRITE: begin
					ptr_we = 1'b1; ptr_wa = pi; ptr_wd = pv + {57'd0, sz};
					r_op = MEM_WRITE; r_addr = pv; r_size = sz; r_data = xd;
				end
				OP_JUMP, OP_JUMPIF: begin
					if (q_item.opcode == OP_JUMP || cnd) begin
						pc_n = tgt;
						if (tgt == base) halt_n = 1'b1;
					end
				end
				OP_CALL: begin
					gp_we = 1'b1; gp_wa = RetReg; gp_wd = npc; pc_n = q_item.konst;
				end
				OP_SETCTR: begin ptr_we = 1'b1; ptr_wa = pi; ptr_wd = xd; end
				OP_GETCTR: begin
					gp_we = 1'b1;
					gp_wd = pv;
				end
				OP_RETURN: pc_n = gp_q[RetReg];
				default: begin
					case (q_item.opcode)
						OP_OR2, OP_OR2I, OP_AND2, OP_AND2I: res = xd;
						default: res = xm;
					endcase
					case (q_item.opcode)
						OP_OR2I, OP_AND2I, OP_AND3I, OP_OR3I, OP_XOR3I: b = q_item.konst;
						OP_OR2, OP_AND2: b = xm;
						default: b = xn;
					endcase
					case (q_item.opcode)
						OP_OR2, OP_OR2I, OP_OR3, OP_OR3I: res = res | b;
						OP_AND2, OP_AND2I, OP_AND3, OP_AND3I: res = res & b;
						default: res = res ^ b;
					endcase
					gp_we = 1'b1; gp_wd = res;
					flags_n = {res[63], res == '0, 1'b0, flags_q[0]};
				end
			endcase
			// A counter write to PC overrides the advanced PC.
			if (ptr_we && ptr_wa == PtrPc) begin
				pc_n = ptr_wd; ptr_we = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) gp_q[i] <= '0;
			for (int i = 0; i < 4; i++) ptr_q[i] <= '0;
			text_base_q   <= '0;
			flags_q       <= '0;
			halt_q        <= 1'b0;
			pend_valid_q  <= 1'b0;
			pend_signed_q <= 1'b0;
			pend_reg_q    <= '0;
			pend_size_q   <= '0;
			ov_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_STACK: ptr_q[1] <= cfg_data;
					CFG_DATA:  ptr_q[2] <= cfg_data;
					CFG_VRAM:  ptr_q[3] <= cfg_data;
					default:   text_base_q <= cfg_data;
				endcase
			end
			if (q_pop) begin
				if (gp_we) gp_q[gp_wa] <= gp_wd;
				ptr_q[PtrPc] <= pc_n;
				if (ptr_we) ptr_q[ptr_wa] <= ptr_wd;
				flags_q <= flags_n;
				halt_q  <= halt_n;
				if (pend_set) begin
					pend_valid_q  <= 1'b1;
					pend_reg_q    <= q_item.reg_d;
					pend_signed_q <= (q_item.opcode == OP_READSE);
					pend_size_q   <= sz;
				end else if (pend_clr) begin
					pend_valid_q <= 1'b0;
				end
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mem_op     <= r_op;
			mem_addr   <= r_addr;
			mem_size   <= r_size;
			store_data <= r_data;
			pc_value   <= pc_n;
			flags_nzcv <= flags_n;
			halted     <= halt_n;
			status     <= r_st;
		end
	end

	assign out_valid = ov_q;

endmodule

/* rtl/core/isa_execute_unit.sv */
// ----------------------------------------------------------------------------
// isa_execute_unit: execute stage of a 64-bit ISA
// Front classifier, two-entry queue and a single-pass execute back end.
// ----------------------------------------------------------------------------
// Each accepted beat is either a decoded instruction or the data answering
// the last read request, and each produces exactly one result beat carrying a
// memory request, the new PC, the flags, the halt flag and a status code. A
// beat is classified and placed in a two-entry queue in the cycle it is
// accepted; the back end retires one queued beat per cycle while the output is
// free or taken, through a single ALU pass that reads and writes the register
// file directly; output valid rises once the beat has passed the queue and
// the output register, which is refilled in the cycle its result is taken, so
// a stalled output only stops the back end, and the queue absorbs two further
// beats before input ready falls. Base register writes load SP, A0, A1 or the
// text base at once and should only be made while the unit is idle.
module isa_execute_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [5:0]         opcode,
	input  logic [2:0]         reg_d,
	input  logic [2:0]         reg_m,
	input  logic [2:0]         reg_n,
	input  logic [2:0]         small_select,
	input  logic [6:0]         size_or_shift,
	input  logic signed [63:0] constant,
	input  logic [6:0]         insn_length,
	input  logic [63:0]        load_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         mem_op,
	output logic [63:0]        mem_addr,
	output logic [6:0]         mem_size,
	output logic [63:0]        store_data,
	output logic [63:0]        pc_value,
	output logic [3:0]         flags_nzcv,
	output logic               halted,
	output logic [1:0]         status
);
	import ieu_pkg::*;

	logic      q_valid, q_pop;
	ieu_item_t q_item;

	ieu_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.req_type(req_type), .opcode(opcode), .reg_d(reg_d), .reg_m(reg_m),
		.reg_n(reg_n), .small_select(small_select), .size_or_shift(size_or_shift),
		.constant(constant), .insn_length(insn_length), .load_data(load_data),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	ieu_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready), .mem_op(mem_op),
		.mem_addr(mem_addr), .mem_size(mem_size), .store_data(store_data),
		.pc_value(pc_value), .flags_nzcv(flags_nzcv), .halted(halted),
		.status(status)
	);

endmodule
